/* hdl/weighted_round_robin_task_scheduler_top_macros.svh */
// Assertion macros shared by the scheduler's checker.
// Needs signals named clk and rst_n in the scope that uses them.
`ifndef WEIGHTED_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define WRRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WRRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wrrs_pkg.sv */
// Types and constants of the weighted round-robin task scheduler.
// No dependencies.
package wrrs_pkg;

    typedef enum logic [1:0] {
        ST_DEAD     = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEPING = 2'd3
    } slot_st_t;

    typedef enum logic [2:0] {
        CMD_SCHED  = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_KILL   = 3'd2,
        CMD_SLEEP  = 3'd3,
        CMD_EXIT   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SLOT    = 2'd1,
        STAT_BAD_TARGET = 2'd2,
        STAT_IDLE       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_SCAN,
        S_CREATE,
        S_KILL,
        S_DONE
    } seq_t;

    // ceil(ms/20) = ((ms+19)>>2)/5, divide by 5 via reciprocal
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
    localparam int          RECIP5_SH  = 34;
    localparam logic [32:0] ROUND_ADD  = 33'd19;
    localparam int          TICK_W     = 29;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now;
        logic [7:0]  weight;
        logic [3:0]  target_id;
        logic [31:0] sleep_ms;
    } item_t;

    typedef struct packed {
        logic [3:0] running_task;
        logic       switched;
        status_t    status;
        logic [3:0] created_slot;
        logic       exit_requested;
        logic [4:0] runnable_count;
    } res_t;

    typedef struct packed {
        slot_st_t    st;
        logic [7:0]  weight;
        logic [7:0]  slices;
        logic [31:0] wake;
        logic        kill;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

/* hdl/wrrs_chan_if.sv */
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface wrrs_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/wrrs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/wrrs_engine.sv */
// Command sequencer: read-modify-write of the task table and the rotating scan.
// Depends on wrrs_pkg.
module wrrs_engine #(
    parameter int SLOT_COUNT = 16,
    localparam int AW = $clog2(SLOT_COUNT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  wrrs_pkg::item_t     in_data,
    output logic                in_ready,
    input  wrrs_pkg::entry_t    rd_data,
    output wrrs_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       wr_addr,
    output wrrs_pkg::entry_t    wr_data,
    output logic                res_valid,
    output wrrs_pkg::res_t      res,
    input  logic                res_take
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
    localparam logic [AW-1:0] SCAN_REM  = AW'(SLOT_COUNT - 2);

    wrrs_pkg::seq_t    state_reg, state_next;
    wrrs_pkg::item_t   item_reg, item_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     before_reg, before_next;
    logic              cur_kill_reg, cur_kill_next;
    logic [AW-1:0]     cnt_reg, cnt_next;       // runnable slots other than idle
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     rem_reg, rem_next;
    logic [wrrs_pkg::TICK_W-1:0] tick_reg, tick_next;
    wrrs_pkg::status_t status_reg, status_next;
    logic [3:0]        created_reg, created_next;

    wrrs_pkg::entry_t  e;
    logic              accept;
    logic [AW-1:0]     cur_succ, ptr_succ;
    logic              e_run, keep_cur, found, e_dead, target_bad;
    wrrs_pkg::slot_st_t cur_st2;
    logic [30:0]       ms_q;
    logic [62:0]       prod;
    logic [wrrs_pkg::TICK_W-1:0] tick_adj;
    logic [31:0]       wake_new;
    logic [7:0]        w_adj;
    logic [31:0]       cnt_tot;

    assign e        = rd_data;
    assign accept   = in_valid && (state_reg == wrrs_pkg::S_IDLE);
    assign in_ready = (state_reg == wrrs_pkg::S_IDLE);

    // scan order skips the idle slot
    assign cur_succ = (cur_reg == LAST_SLOT) ? AW'(1) : cur_reg + AW'(1);
    assign ptr_succ = (ptr_reg == LAST_SLOT) ? AW'(1) : ptr_reg + AW'(1);

    assign e_dead   = (e.st == wrrs_pkg::ST_DEAD);
    assign e_run    = (e.st == wrrs_pkg::ST_READY) || (e.st == wrrs_pkg::ST_RUNNING);
    assign cur_st2  = (e.st == wrrs_pkg::ST_RUNNING) ? wrrs_pkg::ST_READY : e.st;
    assign keep_cur = (cur_st2 == wrrs_pkg::ST_READY) && (e.slices != 8'd0);
    assign found    = (e.st == wrrs_pkg::ST_READY) ||
                      ((e.st == wrrs_pkg::ST_SLEEPING) && (item_reg.now >= e.wake));

    assign target_bad = (in_data.target_id == 4'd0) ||
                        (32'(in_data.target_id) >= 32'(SLOT_COUNT));

    assign ms_q     = 31'((33'(in_data.sleep_ms) + wrrs_pkg::ROUND_ADD) >> 2);
    assign prod     = 63'(ms_q) * 63'(wrrs_pkg::RECIP5);
    assign tick_adj = (tick_reg == '0) ? wrrs_pkg::TICK_W'(1) : tick_reg;
    assign wake_new = item_reg.now + 32'(tick_adj);
    assign w_adj    = (item_reg.weight == 8'd0) ? 8'd1 : item_reg.weight;

    assign cnt_tot  = 32'(cnt_reg) + 32'd1;

    always_comb
    begin
        res.running_task   = 4'(cur_reg);
        res.switched       = (cur_reg != before_reg);
        res.status         = status_reg;
        res.created_slot   = created_reg;
        res.exit_requested = cur_kill_reg;
        res.runnable_count = (cnt_tot > 32'd31) ? 5'd31 : 5'(cnt_tot);
    end
    assign res_valid = (state_reg == wrrs_pkg::S_DONE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrrs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.cmd)
                        wrrs_pkg::CMD_SCHED:
                            state_next = (cur_reg == '0) ? wrrs_pkg::S_SCAN : wrrs_pkg::S_CUR;
                        wrrs_pkg::CMD_CREATE:
                            state_next = wrrs_pkg::S_CREATE;
                        wrrs_pkg::CMD_KILL:
                            state_next = target_bad ? wrrs_pkg::S_DONE : wrrs_pkg::S_KILL;
                        wrrs_pkg::CMD_SLEEP, wrrs_pkg::CMD_EXIT:
                            state_next = (cur_reg == '0) ? wrrs_pkg::S_DONE : wrrs_pkg::S_CUR;
                        default:
                            state_next = wrrs_pkg::S_DONE;
                    endcase
                end
            end
            wrrs_pkg::S_CUR:
            begin
                unique case (item_reg.cmd)
                    wrrs_pkg::CMD_SCHED:
                        state_next = keep_cur ? wrrs_pkg::S_DONE : wrrs_pkg::S_SCAN;
                    wrrs_pkg::CMD_SLEEP:
                        state_next = e_dead ? wrrs_pkg::S_DONE : wrrs_pkg::S_SCAN;
                    default:
                        state_next = wrrs_pkg::S_DONE;
                endcase
            end
            wrrs_pkg::S_SCAN:
                state_next = (found || rem_reg == '0) ? wrrs_pkg::S_DONE : wrrs_pkg::S_SCAN;
            wrrs_pkg::S_CREATE:
                state_next = (e_dead || rem_reg == '0) ? wrrs_pkg::S_DONE : wrrs_pkg::S_CREATE;
            wrrs_pkg::S_KILL:
                state_next = wrrs_pkg::S_DONE;
            wrrs_pkg::S_DONE:
                state_next = res_take ? wrrs_pkg::S_IDLE : wrrs_pkg::S_DONE;
            default:
                state_next = wrrs_pkg::S_IDLE;
        endcase
    end

    // memory commands and datapath
    always_comb
    begin
        item_next     = item_reg;
        cur_next      = cur_reg;
        before_next   = before_reg;
        cur_kill_next = cur_kill_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        rem_next      = rem_reg;
        tick_next     = tick_reg;
        status_next   = status_reg;
        created_next  = created_reg;
        mem_ctl       = '0;
        rd_addr       = ptr_reg;
        wr_addr       = ptr_reg;
        wr_data       = e;

        unique case (state_reg)
            wrrs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next    = in_data;
                    before_next  = cur_reg;
                    status_next  = wrrs_pkg::STAT_OK;
                    created_next = 4'd0;
                    tick_next    = prod[62:wrrs_pkg::RECIP5_SH];
                    unique case (in_data.cmd)
                        wrrs_pkg::CMD_SCHED:
                        begin
                            mem_ctl.rd_en = 1'b1;
                            if (cur_reg == '0)
                            begin
                                rd_addr  = cur_succ;
                                ptr_next = cur_succ;
                                rem_next = SCAN_REM;
                            end
                            else
                            begin
                                rd_addr  = cur_reg;
                                ptr_next = cur_reg;
                            end
                        end
                        wrrs_pkg::CMD_CREATE:
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = AW'(1);
                            ptr_next      = AW'(1);
                            rem_next      = SCAN_REM;
                        end
                        wrrs_pkg::CMD_KILL:
                        begin
                            if (target_bad)
                            begin
                                status_next = wrrs_pkg::STAT_BAD_TARGET;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = AW'(in_data.target_id);
                                ptr_next      = AW'(in_data.target_id);
                            end
                        end
                        wrrs_pkg::CMD_SLEEP, wrrs_pkg::CMD_EXIT:
                        begin
                            if (cur_reg == '0)
                            begin
                                status_next = wrrs_pkg::STAT_IDLE;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = cur_reg;
                                ptr_next      = cur_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            wrrs_pkg::S_CUR:
            begin
                wr_addr = cur_reg;
                unique case (item_reg.cmd)
                    wrrs_pkg::CMD_SCHED:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        if (keep_cur)
                        begin
                            wr_data.st     = wrrs_pkg::ST_RUNNING;
                            wr_data.slices = e.slices - 8'd1;
                        end
                        else
                        begin
                            wr_data.st    = cur_st2;
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = cur_succ;
                            ptr_next      = cur_succ;
                            rem_next      = SCAN_REM;
                        end
                    end
                    wrrs_pkg::CMD_SLEEP:
                    begin
                        if (e_dead)
                        begin
                            status_next = wrrs_pkg::STAT_BAD_TARGET;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_data.st    = wrrs_pkg::ST_SLEEPING;
                            wr_data.wake  = wake_new;
                            cnt_next      = cnt_reg - AW'(e_run);
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = cur_succ;
                            ptr_next      = cur_succ;
                            rem_next      = SCAN_REM;
                        end
                    end
                    default:
                    begin
                        if (e_dead)
                        begin
                            status_next = wrrs_pkg::STAT_BAD_TARGET;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_data.st    = wrrs_pkg::ST_DEAD;
                            wr_data.kill  = 1'b0;
                            cnt_next      = cnt_reg - AW'(e_run);
                            cur_kill_next = 1'b0;
                        end
                    end
                endcase
            end
            wrrs_pkg::S_SCAN:
            begin
                priority if (found)
                begin
                    mem_ctl.wr_en  = 1'b1;
                    wr_data.st     = wrrs_pkg::ST_RUNNING;
                    wr_data.slices = e.weight - 8'd1;
                    cnt_next       = cnt_reg + AW'(e.st == wrrs_pkg::ST_SLEEPING);
                    cur_next       = ptr_reg;
                    cur_kill_next  = e.kill;
                end
                else if (rem_reg == '0)
                begin
                    // nothing ready: idle task takes over
                    cur_next      = '0;
                    cur_kill_next = 1'b0;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_succ;
                    ptr_next      = ptr_succ;
                    rem_next      = rem_reg - AW'(1);
                end
            end
            wrrs_pkg::S_CREATE:
            begin
                priority if (e_dead)
                begin
                    mem_ctl.wr_en  = 1'b1;
                    wr_data.st     = wrrs_pkg::ST_READY;
                    wr_data.weight = w_adj;
                    wr_data.slices = w_adj;
                    wr_data.wake   = 32'd0;
                    wr_data.kill   = 1'b0;
                    cnt_next       = cnt_reg + AW'(1);
                    created_next   = 4'(ptr_reg);
                    if (ptr_reg == cur_reg)
                    begin
                        cur_kill_next = 1'b0;
                    end
                end
                else if (rem_reg == '0)
                begin
                    status_next = wrrs_pkg::STAT_NO_SLOT;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_reg + AW'(1);
                    ptr_next      = ptr_reg + AW'(1);
                    rem_next      = rem_reg - AW'(1);
                end
            end
            wrrs_pkg::S_KILL:
            begin
                if (e_dead)
                begin
                    status_next = wrrs_pkg::STAT_BAD_TARGET;
                end
                else
                begin
                    mem_ctl.wr_en = 1'b1;
                    wr_data.kill  = 1'b1;
                    if (ptr_reg == cur_reg)
                    begin
                        cur_kill_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wrrs_pkg::S_IDLE;
            cur_reg      <= '0;
            before_reg   <= '0;
            cur_kill_reg <= 1'b0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            rem_reg      <= '0;
            status_reg   <= wrrs_pkg::STAT_OK;
            created_reg  <= 4'd0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            before_reg   <= before_next;
            cur_kill_reg <= cur_kill_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            rem_reg      <= rem_next;
            status_reg   <= status_next;
            created_reg  <= created_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        tick_reg <= tick_next;
    end

endmodule

/* hdl/weighted_round_robin_task_scheduler_top.sv */
// Schedule and sleep read the table one slot at a time in the rotating scan through the
// one-read-port table RAM; create reads slots in turn until it finds a dead one, kill and exit
// read a single slot, and rejected and unknown words go straight to the result.
// Throughput: one word at a time; the next word is taken once the result is registered.
// The result register lets a new word in while the previous result waits.
// Reset: asynchronous, active low; idle slot current, all other slots read as dead
// through per-slot valid bits, so no clearing pass is needed.
module weighted_round_robin_task_scheduler_top #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    wrrs_chan_if.sink   req,
    wrrs_chan_if.source rsp
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int EW = $bits(wrrs_pkg::entry_t);

    wrrs_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      rd_addr, wr_addr;
    wrrs_pkg::entry_t   wr_data, rd_entry;
    logic [EW-1:0]      ram_q;
    logic               res_valid, res_take;
    wrrs_pkg::res_t     res;

    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic                  vld_q_reg;
    logic                  fwd_hit_reg;
    wrrs_pkg::entry_t      fwd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    wrrs_pkg::res_t        out_data_reg;

    wrrs_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    wrrs_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_data   (req.data),
        .in_ready  (req.ready),
        .rd_data   (rd_entry),
        .mem_ctl   (mem_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // unwritten entries read as dead/zero; same-cycle write is forwarded
    always_comb
    begin
        priority if (fwd_hit_reg)
            rd_entry = fwd_data_reg;
        else if (vld_q_reg)
            rd_entry = wrrs_pkg::entry_t'(ram_q);
        else
            rd_entry = '0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (mem_ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            vld_q_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (mem_ctl.rd_en)
            begin
                vld_q_reg   <= valid_reg[rd_addr];
                fwd_hit_reg <= mem_ctl.wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // result register
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

/* hdl/wrrs_check.sv */
// Port-level checker for the scheduler top, attached by bind.
// Depends on wrrs_pkg and the assertion macro header.
`include "weighted_round_robin_task_scheduler_top_macros.svh"

module wrrs_check (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input wrrs_pkg::res_t rsp_data
);

    `WRRS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word changed while stalled")
    `WRRS_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second word taken while busy")
    `WRRS_ASSERT_IMP(a_idle_runnable, rsp_valid, rsp_data.runnable_count != 5'd0, "idle slot not counted")
    `WRRS_ASSERT_IMP(a_full_no_slot, rsp_valid && rsp_data.status == wrrs_pkg::STAT_NO_SLOT, rsp_data.created_slot == 4'd0, "slot reported on full table")
    `WRRS_ASSERT_IMP(a_idle_no_kill, rsp_valid && rsp_data.running_task == 4'd0, !rsp_data.exit_requested, "idle slot flagged for kill")

endmodule

bind weighted_round_robin_task_scheduler_top wrrs_check u_wrrs_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
